/* rtl/eomc_pkg.sv */
// Shared widths, register indexes, configuration bundle and reciprocal table
// for the Monte Carlo option pricer. No dependencies.
package eomc_pkg;

  // Fixed point formats
  localparam int SAMPLE_FRAC_BITS = 20;
  localparam int PRICE_W          = 32;
  localparam int SAMPLE_W         = 24;
  localparam int TIME_W           = 24;
  localparam int RATE_W           = 21;
  localparam int VOL_W            = 23;
  localparam int COUNT_W          = 25;
  localparam int ARG_W            = 33;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_INDEX_W      = 3;

  // Exponential unit constants
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam int          EXP_LIMIT = 40;
  localparam int          TAYLOR_N  = 15;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SPOT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIKE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VOL    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATHS  = 3'd5;

  // Reset values of the registers
  localparam logic [PRICE_W-1:0]       SPOT_RST   = 32'd6553600;
  localparam logic [PRICE_W-1:0]       STRIKE_RST = 32'd6553600;
  localparam logic [TIME_W-1:0]        TIME_RST   = 24'd1048576;
  localparam logic signed [RATE_W-1:0] RATE_RST   = 21'sd52429;
  localparam logic [VOL_W-1:0]         VOL_RST    = 23'd209715;
  localparam logic [COUNT_W-1:0]       PATHS_RST  = 25'd1000000;

  // Settings the back part needs from the front part
  typedef struct packed {
    logic [PRICE_W-1:0]      spot;
    logic [PRICE_W-1:0]      strike;
    logic [COUNT_W-1:0]      paths;
    logic signed [ARG_W-1:0] disc_arg;
  } eomc_cfg_t;

  // floor(2^32 / n) for the Taylor term divisors
  function automatic logic [31:0] recip_q32(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      4'd13:   r = 32'd330382099;
      4'd14:   r = 32'd306783378;
      4'd15:   r = 32'd286331153;
      default: r = 32'hFFFFFFFF;
    endcase
    return r;
  endfunction

endpackage

/* rtl/eomc_in_if.sv */
// Sample channel: valid/ready handshake carrying one normal draw.
// Depends on eomc_pkg.
interface eomc_in_if;
  import eomc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] normal_sample;

  modport source(output valid, output normal_sample, input ready);
  modport sink(input valid, input normal_sample, output ready);
endinterface

/* rtl/eomc_out_if.sv */
// Price channel: valid/ready handshake carrying the call and put values.
// Depends on eomc_pkg.
interface eomc_out_if;
  import eomc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] call_value;
  logic [PRICE_W-1:0] put_value;

  modport source(output valid, output call_value, output put_value, input ready);
  modport sink(input valid, input call_value, input put_value, output ready);
endinterface

/* rtl/european_option_monte_carlo_core.sv */
// Top level of the Monte Carlo European option pricer.
// Depends on eomc_pkg, eomc_in_if, eomc_out_if, eomc_fifo, eomc_front, eomc_back.
//
//   channel   dir  payload                      transfer when
//   samples   in   normal_sample (Q4.20)        samples.valid && samples.ready
//   prices    out  call_value, put_value        prices.valid && prices.ready
//   cfg       in   cfg_index, cfg_data          cfg_wr_en
//
// Each sample in the back part passes through the shared scaling unit: ln 2
// range reduction, then per Taylor term a multiply, a reciprocal and a correction.
// A completed batch adds a division of both sums by the path count and two
// more scaling passes. After reset or any register write the front recomputes
// the exponent coefficients, with samples.ready low. A stalled price output
// holds the back part only when a second result is ready to leave.
module european_option_monte_carlo_core #(
  parameter int QUEUE_DEPTH = eomc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [eomc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [eomc_pkg::CFG_DATA_W-1:0]  cfg_data,
  eomc_in_if.sink                          samples,
  eomc_out_if.source                       prices
);
  import eomc_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  eomc_cfg_t               cfg;
  logic                    push;
  logic signed [ARG_W-1:0] push_data;
  logic                    pop;
  logic [ARG_W-1:0]        pop_data;
  logic                    q_valid;
  logic [LVL_W-1:0]        level;

  eomc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .level     (level),
    .push      (push),
    .push_data (push_data),
    .cfg       (cfg)
  );

  eomc_fifo #(
    .WIDTH (ARG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .valid     (q_valid),
    .level     (level)
  );

  eomc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  ($signed(pop_data)),
    .q_pop   (pop),
    .prices  (prices)
  );

endmodule

/* rtl/eomc_fifo.sv */
// Small register queue between the front and back parts.
// Depends on nothing but its parameters.
module eomc_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       valid,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign valid    = (level != '0);
  assign pop_data = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < LVL_W'(DEPTH)) || pop)
    else $error("queue written while full");

endmodule

/* rtl/eomc_front.sv */
// Front part: configuration registers, precomputation of the exponent
// coefficients and per-sample exponent argument. Depends on eomc_pkg, eomc_in_if.
module eomc_front #(
  parameter int QUEUE_DEPTH = eomc_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [eomc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [eomc_pkg::CFG_DATA_W-1:0]      cfg_data,
  eomc_in_if.sink                              samples,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     level,
  output logic                                 push,
  output logic signed [eomc_pkg::ARG_W-1:0]    push_data,
  output eomc_pkg::eomc_cfg_t                  cfg
);
  import eomc_pkg::*;

  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RAD_W  = TIME_W + SAMPLE_FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);
  localparam int HS_W   = 2 * VOL_W - SAMPLE_FRAC_BITS - 1;
  localparam int DIFF_W = HS_W + 2;
  localparam int DP_W   = DIFF_W + TIME_W + 1;
  localparam int COEF_W = VOL_W + ROOT_W - SAMPLE_FRAC_BITS;
  localparam int ZP_W   = COEF_W + 1 + SAMPLE_W;
  localparam int YP_W   = RATE_W + TIME_W + 2;

  typedef enum logic [5:0] {
    P_HS    = 6'b000001,
    P_DRIFT = 6'b000010,
    P_SQRT  = 6'b000100,
    P_COEF  = 6'b001000,
    P_Y     = 6'b010000,
    P_RUN   = 6'b100000
  } prep_state_t;

  prep_state_t               state;
  logic [PRICE_W-1:0]        spot;
  logic [PRICE_W-1:0]        strike;
  logic [TIME_W-1:0]         tte;
  logic signed [RATE_W-1:0]  rate;
  logic [VOL_W-1:0]          vol;
  logic [COUNT_W-1:0]        paths;

  logic [HS_W-1:0]           hs;
  logic signed [31:0]        drift;
  logic [RAD_W-1:0]          rad;
  logic [REM_W-3:0]          rem;
  logic [ROOT_W-1:0]         root;
  logic [CNT_W-1:0]          cnt;
  logic [COEF_W-1:0]         coef;
  logic signed [ARG_W-1:0]   disc_arg;

  logic                      a_v;
  logic signed [ZP_W-1:0]    a_prod;

  logic [2*VOL_W-1:0]        hs_prod;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DP_W-1:0]    drift_prod;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic [VOL_W+ROOT_W-1:0]   coef_prod;
  logic signed [YP_W-1:0]    y_prod;
  logic                      accept;

  // Coefficient arithmetic for the precomputation steps
  always_comb begin
    hs_prod    = vol * vol;
    diff       = DIFF_W'(rate) - $signed({2'b00, hs});
    drift_prod = DP_W'(diff) * $signed({1'b0, tte});
    rem_sh     = {rem, rad[RAD_W-1 -: 2]};
    trial      = {root, 2'b01};
    coef_prod  = vol * root;
    y_prod     = -(YP_W'(rate) * $signed({1'b0, tte}));
  end

  // Room for the item now being taken and the one in flight
  assign samples.ready = (state == P_RUN) &&
                         ((LVL_W + 1)'(level) + (LVL_W + 1)'(a_v) < (LVL_W + 1)'(QUEUE_DEPTH));
  assign accept = samples.valid && samples.ready;

  // Configuration registers and the precomputation sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= P_HS;
      spot   <= SPOT_RST;
      strike <= STRIKE_RST;
      tte    <= TIME_RST;
      rate   <= RATE_RST;
      vol    <= VOL_RST;
      paths  <= PATHS_RST;
    end else if (cfg_wr_en) begin
      state <= P_HS;
      case (cfg_index)
        REG_SPOT:   spot   <= cfg_data;
        REG_STRIKE: strike <= cfg_data;
        REG_TIME:   tte    <= cfg_data[TIME_W-1:0];
        REG_RATE:   rate   <= cfg_data[RATE_W-1:0];
        REG_VOL:    vol    <= cfg_data[VOL_W-1:0];
        REG_PATHS:  paths  <= cfg_data[COUNT_W-1:0];
        default:    ;
      endcase
    end else begin
      unique case (state)
        P_HS: begin
          hs    <= hs_prod[2*VOL_W-1:SAMPLE_FRAC_BITS+1];
          state <= P_DRIFT;
        end
        P_DRIFT: begin
          drift <= 32'(drift_prod >>> SAMPLE_FRAC_BITS);
          rad   <= {tte, SAMPLE_FRAC_BITS'(0)};
          rem   <= '0;
          root  <= '0;
          cnt   <= CNT_W'(ROOT_W);
          state <= P_SQRT;
        end
        P_SQRT: begin
          // One root bit per cycle
          if (rem_sh >= trial) begin
            rem  <= (REM_W-2)'(rem_sh - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[REM_W-3:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad <= {rad[RAD_W-3:0], 2'b00};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= P_COEF;
          end
        end
        P_COEF: begin
          coef  <= coef_prod[VOL_W+ROOT_W-1:SAMPLE_FRAC_BITS];
          state <= P_Y;
        end
        P_Y: begin
          disc_arg <= ARG_W'(y_prod >>> SAMPLE_FRAC_BITS);
          state    <= P_RUN;
        end
        P_RUN: ;
        default: state <= P_HS;
      endcase
    end
  end

  // Sample path: multiply by the coefficient, then add the drift
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_prod <= $signed({1'b0, coef}) * samples.normal_sample;
    end
  end

  assign push      = a_v;
  assign push_data = ARG_W'(drift) + ARG_W'(a_prod >>> SAMPLE_FRAC_BITS);

  assign cfg.spot     = spot;
  assign cfg.strike   = strike;
  assign cfg.paths    = paths;
  assign cfg.disc_arg = disc_arg;

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !samples.ready)
    else $error("sample taken before coefficients were recomputed");

endmodule

/* rtl/eomc_exp.sv */
// Sequential scaling unit: v * exp(x) with range reduction by ln 2 and a
// Taylor series to the fifteenth power, saturated to 32 bits. Depends on eomc_pkg.
module eomc_exp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [eomc_pkg::PRICE_W-1:0]      v,
  input  logic signed [eomc_pkg::ARG_W-1:0] x,
  output logic                              busy,
  output logic                              done,
  output logic [eomc_pkg::PRICE_W-1:0]      result
);
  import eomc_pkg::*;

  localparam int SCALE_SHIFT = 32 - SAMPLE_FRAC_BITS;
  localparam int WIDE_W      = ARG_W + SCALE_SHIFT;
  localparam int Q_W         = $clog2(EXP_LIMIT) + 1;
  localparam int MAG_W       = 32 + Q_W - 1;
  localparam int BIT_W       = $clog2(Q_W);
  localparam logic signed [ARG_W-1:0] ARG_MAX =
    ARG_W'(EXP_LIMIT * (1 << SAMPLE_FRAC_BITS));
  localparam logic [63:0] MAX32 = 64'h00000000FFFFFFFF;

  typedef enum logic [7:0] {
    E_IDLE = 8'b00000001,
    E_DIV  = 8'b00000010,
    E_FIX  = 8'b00000100,
    E_MUL  = 8'b00001000,
    E_RCP  = 8'b00010000,
    E_COR  = 8'b00100000,
    E_SCL  = 8'b01000000,
    E_SHF  = 8'b10000000
  } exp_state_t;

  exp_state_t         state;
  logic               neg;
  logic [MAG_W-1:0]   rem;
  logic [Q_W-1:0]     q;
  logic [BIT_W-1:0]   bitc;
  logic signed [8:0]  k;
  logic [31:0]        f;
  logic [31:0]        term;
  logic [33:0]        e;
  logic [3:0]         n;
  logic [63:0]        prod;
  logic [31:0]        vreg;

  logic signed [ARG_W-1:0]  xc;
  logic signed [WIDE_W-1:0] x_wide;
  logic signed [WIDE_W-1:0] x_abs;
  logic [MAG_W-1:0]         lsh;
  logic signed [8:0]        k_fix;
  logic [31:0]              f_fix;
  logic [63:0]              rcp_prod;
  logic [31:0]              qe;
  logic [35:0]              rchk;
  logic [31:0]              qf;
  logic [8:0]               rs;
  logic [8:0]               sh;
  logic [63:0]              sr;
  logic [63:0]              sl;
  logic [31:0]              res;

  assign busy = (state != E_IDLE);

  // Clamp and convert the argument to a Q.32 magnitude
  always_comb begin
    if (x > ARG_MAX) begin
      xc = ARG_MAX;
    end else if (x < -ARG_MAX) begin
      xc = -ARG_MAX;
    end else begin
      xc = x;
    end
    x_wide = WIDE_W'(xc) <<< SCALE_SHIFT;
    x_abs  = (xc < 0) ? -x_wide : x_wide;
  end

  // Range reduction, series step and final shift
  always_comb begin
    lsh = MAG_W'(LN2_Q32) << bitc;
    if (!neg) begin
      k_fix = $signed({2'b00, q});
      f_fix = rem[31:0];
    end else if (rem != '0) begin
      k_fix = -$signed({2'b00, q}) - 9'sd1;
      f_fix = LN2_Q32 - rem[31:0];
    end else begin
      k_fix = -$signed({2'b00, q});
      f_fix = '0;
    end

    rcp_prod = prod[63:32] * recip_q32(n);
    qe       = prod[63:32];
    rchk     = {4'b0000, term} - (36'(qe) * 36'(n));
    qf       = (rchk >= 36'(n)) ? qe + 1'b1 : qe;

    rs = 9'(9'sd31 - k);
    sh = 9'(k - 9'sd31);
    sr = prod >> rs[5:0];
    sl = prod << sh[4:0];
    if (k < 9'sd31) begin
      if (rs >= 9'd64) begin
        res = '0;
      end else if (sr[63:32] != '0) begin
        res = MAX32[31:0];
      end else begin
        res = sr[31:0];
      end
    end else begin
      if (prod == '0) begin
        res = '0;
      end else if (sh >= 9'd32 || prod > (MAX32 >> sh[4:0])) begin
        res = MAX32[31:0];
      end else begin
        res = sl[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            neg   <= (xc < 0);
            rem   <= x_abs[MAG_W-1:0];
            q     <= '0;
            bitc  <= BIT_W'(Q_W - 1);
            vreg  <= v;
            state <= E_DIV;
          end
        end
        E_DIV: begin
          // Quotient by ln 2, one bit per cycle
          if (rem >= lsh) begin
            rem     <= rem - lsh;
            q[bitc] <= 1'b1;
          end
          if (bitc == '0) begin
            state <= E_FIX;
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        E_FIX: begin
          k     <= k_fix;
          f     <= f_fix;
          term  <= f_fix;
          e     <= {2'b01, 32'd0} + {2'b00, f_fix};
          n     <= 4'd2;
          state <= E_MUL;
        end
        E_MUL: begin
          prod  <= term * f;
          state <= E_RCP;
        end
        E_RCP: begin
          // Divide by n through its reciprocal
          term  <= prod[63:32];
          prod  <= rcp_prod;
          state <= E_COR;
        end
        E_COR: begin
          term <= qf;
          e    <= e + 34'(qf);
          if (n == 4'(TAYLOR_N)) begin
            state <= E_SCL;
          end else begin
            n     <= n + 1'b1;
            state <= E_MUL;
          end
        end
        E_SCL: begin
          prod  <= vreg * e[32:1];
          state <= E_SHF;
        end
        E_SHF: begin
          result <= res;
          done   <= 1'b1;
          state  <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

/* rtl/eomc_back.sv */
// Back part: terminal price, payoff sums, batch division and discounting,
// and the output register. Depends on eomc_pkg, eomc_out_if, eomc_exp.
module eomc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  eomc_pkg::eomc_cfg_t               cfg,
  input  logic                              q_valid,
  input  logic signed [eomc_pkg::ARG_W-1:0] q_data,
  output logic                              q_pop,
  eomc_out_if.source                        prices
);
  import eomc_pkg::*;

  localparam int SUM_W = 64;
  localparam int DC_W  = $clog2(SUM_W);

  typedef enum logic [8:0] {
    B_IDLE   = 9'b000000001,
    B_PATH   = 9'b000000010,
    B_ACC    = 9'b000000100,
    B_DIV    = 9'b000001000,
    B_CSTART = 9'b000010000,
    B_CWAIT  = 9'b000100000,
    B_PSTART = 9'b001000000,
    B_PWAIT  = 9'b010000000,
    B_OUT    = 9'b100000000
  } back_state_t;

  back_state_t        state;
  logic [SUM_W-1:0]   call_sum;
  logic [SUM_W-1:0]   put_sum;
  logic [COUNT_W-1:0] seen;
  logic [PRICE_W-1:0] st;
  logic [COUNT_W-1:0] rem_c;
  logic [COUNT_W-1:0] rem_p;
  logic [DC_W-1:0]    dcnt;
  logic [PRICE_W-1:0] call_res;
  logic [PRICE_W-1:0] put_res;
  logic               out_v;
  logic [PRICE_W-1:0] out_call;
  logic [PRICE_W-1:0] out_put;

  logic                    exp_start;
  logic [PRICE_W-1:0]      exp_v;
  logic signed [ARG_W-1:0] exp_x;
  logic                    exp_busy;
  logic                    exp_done;
  logic [PRICE_W-1:0]      exp_result;

  logic [PRICE_W-1:0] call_pay;
  logic [PRICE_W-1:0] put_pay;
  logic [SUM_W:0]     call_wide;
  logic [SUM_W:0]     put_wide;
  logic [SUM_W-1:0]   call_add;
  logic [SUM_W-1:0]   put_add;
  logic [COUNT_W-1:0] seen_inc;
  logic [COUNT_W-1:0] need;
  logic [COUNT_W:0]   rc_sh;
  logic [COUNT_W:0]   rp_sh;
  logic [COUNT_W:0]   divisor;
  logic               c_ge;
  logic               p_ge;
  logic [PRICE_W-1:0] call_mean;
  logic [PRICE_W-1:0] put_mean;

  // Payoffs, saturating sums and the path count
  always_comb begin
    call_pay  = (st > cfg.strike) ? st - cfg.strike : '0;
    put_pay   = (cfg.strike > st) ? cfg.strike - st : '0;
    call_wide = {1'b0, call_sum} + (SUM_W + 1)'(call_pay);
    put_wide  = {1'b0, put_sum} + (SUM_W + 1)'(put_pay);
    call_add  = call_wide[SUM_W] ? '1 : call_wide[SUM_W-1:0];
    put_add   = put_wide[SUM_W] ? '1 : put_wide[SUM_W-1:0];
    seen_inc  = (seen == '1) ? seen : seen + 1'b1;
    need      = (cfg.paths == '0) ? COUNT_W'(1) : cfg.paths;
  end

  // Restoring division of both sums by the path count
  always_comb begin
    divisor   = {1'b0, seen};
    rc_sh     = {rem_c, call_sum[SUM_W-1]};
    rp_sh     = {rem_p, put_sum[SUM_W-1]};
    c_ge      = (rc_sh >= divisor);
    p_ge      = (rp_sh >= divisor);
    call_mean = (call_sum[SUM_W-1:PRICE_W] != '0) ? '1 : call_sum[PRICE_W-1:0];
    put_mean  = (put_sum[SUM_W-1:PRICE_W] != '0) ? '1 : put_sum[PRICE_W-1:0];
  end

  // Requests to the shared scaling unit
  always_comb begin
    q_pop     = (state == B_IDLE) && q_valid;
    exp_start = q_pop || (state == B_CSTART) || (state == B_PSTART);
    exp_x     = (state == B_IDLE) ? q_data : cfg.disc_arg;
    if (state == B_IDLE) begin
      exp_v = cfg.spot;
    end else if (state == B_CSTART) begin
      exp_v = call_mean;
    end else begin
      exp_v = put_mean;
    end
  end

  eomc_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .v      (exp_v),
    .x      (exp_x),
    .busy   (exp_busy),
    .done   (exp_done),
    .result (exp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      out_v    <= 1'b0;
      call_sum <= '0;
      put_sum  <= '0;
      seen     <= '0;
    end else begin
      if (out_v && prices.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            state <= B_PATH;
          end
        end
        B_PATH: begin
          if (exp_done) begin
            st    <= exp_result;
            state <= B_ACC;
          end
        end
        B_ACC: begin
          call_sum <= call_add;
          put_sum  <= put_add;
          seen     <= seen_inc;
          if (seen_inc >= need) begin
            rem_c <= '0;
            rem_p <= '0;
            dcnt  <= '1;
            state <= B_DIV;
          end else begin
            state <= B_IDLE;
          end
        end
        B_DIV: begin
          // The sum registers shift into quotients, one bit per cycle
          rem_c    <= c_ge ? COUNT_W'(rc_sh - divisor) : rc_sh[COUNT_W-1:0];
          rem_p    <= p_ge ? COUNT_W'(rp_sh - divisor) : rp_sh[COUNT_W-1:0];
          call_sum <= {call_sum[SUM_W-2:0], c_ge};
          put_sum  <= {put_sum[SUM_W-2:0], p_ge};
          if (dcnt == '0) begin
            state <= B_CSTART;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        B_CSTART: state <= B_CWAIT;
        B_CWAIT: begin
          if (exp_done) begin
            call_res <= exp_result;
            state    <= B_PSTART;
          end
        end
        B_PSTART: state <= B_PWAIT;
        B_PWAIT: begin
          if (exp_done) begin
            put_res <= exp_result;
            state   <= B_OUT;
          end
        end
        B_OUT: begin
          // Hand the result to the output register and start a new batch
          if (!out_v || prices.ready) begin
            out_v    <= 1'b1;
            out_call <= call_res;
            out_put  <= put_res;
            call_sum <= '0;
            put_sum  <= '0;
            seen     <= '0;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign prices.valid      = out_v;
  assign prices.call_value = out_call;
  assign prices.put_value  = out_put;

  a_exp_free: assert property (@(posedge clk) disable iff (rst)
    exp_start |-> !exp_busy)
    else $error("scaling unit started while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (seen != '0))
    else $error("batch division by a zero path count");

endmodule

/* verif/eomc_price_checker.sv */
`timescale 1ns / 100ps
// Price checker for the Monte Carlo option pricer: watches the register port and
// both channels, predicts call and put values, and compares. Depends on eomc_pkg.
module eomc_price_checker
  import eomc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  eomc_in_if                     samples,
  eomc_out_if                    prices,
  input  logic                   drained,
  output int                     errors,
  output int                     backlog,
  output int                     n_paths,
  output int                     n_prices
);

  typedef struct {
    logic [PRICE_W-1:0] call_v;
    logic [PRICE_W-1:0] put_v;
  } price_pair_t;

  localparam longint LN2 = 64'sd2977044472;
  localparam longint unsigned MAX32 = 64'hFFFF_FFFF;

  // Model copy of the registers and the batch accumulators.
  logic [PRICE_W-1:0]       spot_q, strike_q;
  logic [TIME_W-1:0]        time_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [VOL_W-1:0]         vol_q;
  logic [COUNT_W-1:0]       paths_q;
  longint unsigned          call_sum, put_sum;
  longint unsigned          seen;
  price_pair_t              expected_prices[$];
  bit                       leftover_flagged;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // v * exp(x) with x in Q.20, saturated to 32 bits.
  function automatic logic [31:0] exp_scale(input logic [31:0] v, input longint x);
    longint lim, x32, k, rs, sh;
    longint unsigned f, term, e, m, prod, r, vv;
    lim = longint'(EXP_LIMIT) <<< SAMPLE_FRAC_BITS;
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    x32 = x * (64'sd1 <<< (32 - SAMPLE_FRAC_BITS));
    if (x32 >= 0) k = x32 / LN2;
    else k = -(((-x32) + LN2 - 1) / LN2);
    f = longint'(x32 - k * LN2);
    term = 64'd1 << 32;
    e = term;
    for (int n = 1; n <= TAYLOR_N; n++) begin
      term = ((term * f) >> 32) / longint'(n);
      e += term;
    end
    m = e >> 1;
    vv = {32'd0, v};
    prod = vv * m;
    if (k < 31) begin
      rs = 31 - k;
      r = (rs >= 64) ? 64'd0 : (prod >> rs);
    end else begin
      sh = k - 31;
      if (prod == 0) r = 0;
      else if (sh >= 32 || prod > (MAX32 >> sh)) r = MAX32;
      else r = prod << sh;
    end
    return (r > MAX32) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  task automatic report(input string what);
    $display("[%0t] price check error: %s", $realtime, what);
    errors++;
  endtask

  // One path: terminal price, payoffs into the sums, batch close-out.
  task automatic price_path(input logic signed [SAMPLE_W-1:0] draw);
    longint z, r, t, hs, drift, coef, x, y;
    longint unsigned sg, root, st, k_px, cm, pm, need, s;
    price_pair_t p;
    z = longint'(draw);
    r = longint'(rate_q);
    t = longint'({40'd0, time_q});
    sg = {41'd0, vol_q};
    hs = longint'((sg * sg) >> (SAMPLE_FRAC_BITS + 1));
    drift = ((r - hs) * t) >>> SAMPLE_FRAC_BITS;
    root = int_sqrt(longint'(t) << SAMPLE_FRAC_BITS);
    coef = longint'((sg * root) >> SAMPLE_FRAC_BITS);
    x = drift + ((coef * z) >>> SAMPLE_FRAC_BITS);
    st = {32'd0, exp_scale(spot_q, x)};
    k_px = {32'd0, strike_q};
    s = call_sum + ((st > k_px) ? st - k_px : 64'd0);
    call_sum = (s < call_sum) ? '1 : s;
    s = put_sum + ((k_px > st) ? k_px - st : 64'd0);
    put_sum = (s < put_sum) ? '1 : s;
    if (seen < 64'h1FF_FFFF) seen++;
    need = (paths_q == 0) ? 64'd1 : {39'd0, paths_q};
    if (seen >= need) begin
      cm = call_sum / seen;
      pm = put_sum / seen;
      if (cm > MAX32) cm = MAX32;
      if (pm > MAX32) pm = MAX32;
      y = (-(r * t)) >>> SAMPLE_FRAC_BITS;
      p.call_v = exp_scale(cm[31:0], y);
      p.put_v = exp_scale(pm[31:0], y);
      expected_prices.push_back(p);
      call_sum = 0;
      put_sum = 0;
      seen = 0;
    end
  endtask

  initial begin
    errors = 0;
    n_paths = 0;
    n_prices = 0;
    leftover_flagged = 0;
  end

  assign backlog = expected_prices.size();

  always @(posedge clk) begin
    if (rst) begin
      spot_q <= SPOT_RST;
      strike_q <= STRIKE_RST;
      time_q <= TIME_RST;
      rate_q <= RATE_RST;
      vol_q <= VOL_RST;
      paths_q <= PATHS_RST;
      call_sum = 0;
      put_sum = 0;
      seen = 0;
      expected_prices.delete();
    end else begin
      // Register writes take effect for later samples only.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SPOT:   spot_q <= cfg_data[PRICE_W-1:0];
          REG_STRIKE: strike_q <= cfg_data[PRICE_W-1:0];
          REG_TIME:   time_q <= cfg_data[TIME_W-1:0];
          REG_RATE:   rate_q <= cfg_data[RATE_W-1:0];
          REG_VOL:    vol_q <= cfg_data[VOL_W-1:0];
          REG_PATHS:  paths_q <= cfg_data[COUNT_W-1:0];
          default:    ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        price_path(samples.normal_sample);
        n_paths++;
      end
      // Compare each price transfer with the oldest prediction.
      if (prices.valid && prices.ready) begin
        n_prices++;
        if (expected_prices.size() == 0) begin
          report($sformatf("unexpected price call=%h put=%h",
                           prices.call_value, prices.put_value));
        end else begin
          price_pair_t p;
          p = expected_prices.pop_front();
          if (prices.call_value !== p.call_v)
            report($sformatf("call value %h, predicted %h", prices.call_value, p.call_v));
          if (prices.put_value !== p.put_v)
            report($sformatf("put value %h, predicted %h", prices.put_value, p.put_v));
        end
      end
      if (drained && !leftover_flagged) begin
        leftover_flagged = 1;
        if (expected_prices.size() != 0)
          report($sformatf("%0d predicted prices never arrived", expected_prices.size()));
      end
    end
  end

endmodule

/* verif/european_option_monte_carlo_core_test.sv */
`timescale 1ns / 100ps
// Top of the option pricer testbench: clock, reset, register writes and sample
// stimulus under several idling phases. Depends on eomc_pkg, the channel
// interfaces, the core and eomc_price_checker.
module european_option_monte_carlo_core_test;
  import eomc_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   drained;
  int                     errors, backlog, n_paths, n_prices;
  int                     idle_pct, stall_pct, settings_used, sent;

  eomc_in_if  samples();
  eomc_out_if prices();

  european_option_monte_carlo_core i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples), .prices(prices)
  );

  eomc_price_checker i_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples), .prices(prices), .drained(drained),
    .errors(errors), .backlog(backlog), .n_paths(n_paths), .n_prices(n_prices)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The price receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    prices.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Let the pipeline empty: all predicted prices out, plus in-flight paths.
  task automatic settle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send(input logic signed [SAMPLE_W-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.normal_sample <= z;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    sent++;
  endtask

  task automatic setup(input logic [31:0] s, input logic [31:0] k, input logic [23:0] t,
                       input logic [20:0] r, input logic [22:0] v, input logic [24:0] n);
    settle();
    write_reg(REG_SPOT, s);
    write_reg(REG_STRIKE, k);
    write_reg(REG_TIME, {8'd0, t});
    write_reg(REG_RATE, {11'd0, r});
    write_reg(REG_VOL, {9'd0, v});
    write_reg(REG_PATHS, {7'd0, n});
    settings_used++;
  endtask

  task automatic random_setup();
    logic [31:0] s, k;
    logic [23:0] t;
    logic [20:0] r;
    logic [22:0] v;
    logic [24:0] n;
    case ($urandom_range(9))
      0: s = 32'd0;
      1: s = 32'hFFFF_FFFF;
      default: s = $urandom_range(32'h1_0000, 32'd400 << 16);
    endcase
    case ($urandom_range(9))
      0: k = 32'd0;
      1: k = 32'hFFFF_FFFF;
      default: k = $urandom_range(32'h1_0000, 32'd400 << 16);
    endcase
    case ($urandom_range(9))
      0: t = 24'd0;
      1: t = 24'hFF_FFFF;
      default: t = $urandom_range(0, 5 << 20);
    endcase
    if ($urandom_range(7) == 0) r = $urandom;
    else r = 21'($urandom_range(0, 314572)) - 21'd104858;
    case ($urandom_range(9))
      0: v = $urandom;
      1: v = 23'd0;
      default: v = $urandom_range(0, 1 << 20);
    endcase
    case ($urandom_range(9))
      0: n = 25'd0;
      1: n = $urandom_range(9, 40);
      default: n = $urandom_range(1, 6);
    endcase
    setup(s, k, t, r, v, n);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_draw();
    if ($urandom_range(3) == 0) return $urandom;
    return SAMPLE_W'($urandom_range(0, 7340032)) - 24'sd3670016;
  endfunction

  initial begin
    int goal;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    samples.valid <= 1'b0;
    samples.normal_sample <= '0;
    drained <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    settings_used = 1;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: sample extremes, one path per price.
    setup(SPOT_RST, STRIKE_RST, TIME_RST, RATE_RST, VOL_RST, 25'd1);
    send(24'sh7F_FFFF);
    send(-24'sh80_0000);
    send(24'sd0);
    send(24'sd1);
    send(-24'sd1);
    send(24'sd1048576);
    send(-24'sd1048576);
    // A path count of zero behaves as one.
    setup(SPOT_RST, STRIKE_RST, TIME_RST, RATE_RST, VOL_RST, 25'd0);
    send(24'sd524288);
    send(-24'sd524288);
    // Zero spot gives a zero terminal price.
    setup(32'd0, STRIKE_RST, TIME_RST, RATE_RST, VOL_RST, 25'd1);
    send(24'sh7F_FFFF);
    // Huge exponents saturate, huge negative ones vanish; discount underflows.
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 21'h0F_FFFF, 23'h7F_FFFF, 25'd1);
    send(24'sh7F_FFFF);
    send(-24'sh80_0000);
    setup(SPOT_RST, 32'd0, 24'hFF_FFFF, 21'h10_0000, 23'h7F_FFFF, 25'h1FF_FFFF);
    // Writes to unknown indexes are ignored.
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'hFFFF_FFFF);
    setup(SPOT_RST, STRIKE_RST, TIME_RST, RATE_RST, VOL_RST, 25'd5);
    send(24'sd100);
    send(-24'sd2000000);
    send(24'sd3000000);
    // Lowering the path count mid-batch closes it on the next path.
    setup(SPOT_RST, STRIKE_RST, TIME_RST, RATE_RST, VOL_RST, 25'd2);
    send(24'sd12345);

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 72; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 72; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      goal = sent + 275;
      while (sent < goal) begin
        random_setup();
        repeat ($urandom_range(15, 45)) send(random_draw());
      end
    end

    // Drain, then check for leftovers and give the verdict.
    samples.valid <= 1'b0;
    for (int c = 0; c < 20000 && backlog != 0; c++) @(posedge clk);
    repeat (300) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d sample transfers and %0d price transfers over %0d register settings.",
             n_paths, n_prices, settings_used);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/eomc_pkg.sv
rtl/eomc_in_if.sv
rtl/eomc_out_if.sv
rtl/eomc_fifo.sv
rtl/eomc_front.sv
rtl/eomc_exp.sv
rtl/eomc_back.sv
rtl/european_option_monte_carlo_core.sv
verif/eomc_price_checker.sv
verif/european_option_monte_carlo_core_test.sv
